[design/isc_pkg.sv]
// isc_pkg: shared constants for the item completeness scanner
// character codes, default widths and character class functions; no dependencies
`default_nettype none

package isc_pkg;

  localparam int POS_WIDTH_DEF   = 16;
  localparam int DEPTH_WIDTH_DEF = 8;
  localparam int CHAR_WIDTH      = 8;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_VT      = 8'h0b;
  localparam logic [7:0] CH_FF      = 8'h0c;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_NUL     = 8'h00;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    is_opener = (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    is_closer = (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

endpackage

`default_nettype wire

[design/item_completeness_scanner_core.sv]
// item_completeness_scanner_core: byte-wise bracket balance and completeness scanner
// depends on isc_pkg for character codes and default widths
//
// usage:
//   input channel carries one text byte per item (char_code) with new_item,
//   which clears all scan state before that byte is taken
//   output channel gives one result per byte: complete, first/last significant
//   character, position of the first one, bracket depth and string/comment flags
//   handshake on both sides is valid/stall; an item moves when valid is high
//   and stall is low
//   path: a byte is taken into the input register, then its result is
//   written into the result register, which presents it
//   throughput: one byte per cycle while the output is not stalled; the scan
//   state update is a single combinational pass from input to result register
//   when the output is stalled the result register holds, the input register
//   keeps its byte and in_stall rises only once both are full
//   reset (rst, synchronous) clears the scan state and empties both registers
`default_nettype none

module item_completeness_scanner_core #(
  parameter int POS_WIDTH   = isc_pkg::POS_WIDTH_DEF,
  parameter int DEPTH_WIDTH = isc_pkg::DEPTH_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic [7:0]             char_code,
  input  wire logic                   new_item,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic                   complete,
  output      logic [7:0]             first_char,
  output      logic [POS_WIDTH-1:0]   first_pos,
  output      logic [7:0]             last_char,
  output      logic [DEPTH_WIDTH-1:0] depth,
  output      logic                   in_string,
  output      logic                   in_block
);

  localparam logic [POS_WIDTH-1:0]   POS_MAX   = {POS_WIDTH{1'b1}};
  localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_new;

  // scan state
  logic                   string_open, string_open_next;
  logic                   escape_pending, escape_pending_next;
  logic                   block_open, block_open_next;
  logic                   star_seen, star_seen_next;
  logic                   line_open, line_open_next;
  logic                   slash_held, slash_held_next;
  logic [POS_WIDTH-1:0]   slash_position, slash_position_next;
  logic [DEPTH_WIDTH-1:0] nest_level, nest_level_next;
  logic [7:0]             first_seen, first_seen_next;
  logic [POS_WIDTH-1:0]   first_at, first_at_next;
  logic [7:0]             last_seen, last_seen_next;
  logic [POS_WIDTH-1:0]   byte_count, byte_count_next;

  logic                 advance;
  logic [7:0]           fc_next;
  logic [7:0]           lc_next;
  logic [POS_WIDTH-1:0] fp_next;
  logic                 complete_next;
  logic                 done;
  logic [POS_WIDTH-1:0] pos;
  logic [7:0]           c;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_char <= char_code;
      s1_new  <= new_item;
    end
  end

  always_comb begin
    c = s1_char;
    // start from cleared state on a new item
    if (s1_new) begin
      string_open_next    = 1'b0;
      escape_pending_next = 1'b0;
      block_open_next     = 1'b0;
      star_seen_next      = 1'b0;
      line_open_next      = 1'b0;
      slash_held_next     = 1'b0;
      slash_position_next = '0;
      nest_level_next     = '0;
      first_seen_next     = '0;
      first_at_next       = '0;
      last_seen_next      = '0;
      byte_count_next     = '0;
    end else begin
      string_open_next    = string_open;
      escape_pending_next = escape_pending;
      block_open_next     = block_open;
      star_seen_next      = star_seen;
      line_open_next      = line_open;
      slash_held_next     = slash_held;
      slash_position_next = slash_position;
      nest_level_next     = nest_level;
      first_seen_next     = first_seen;
      first_at_next       = first_at;
      last_seen_next      = last_seen;
      byte_count_next     = byte_count;
    end
    pos  = byte_count_next;
    done = 1'b0;

    if (string_open_next) begin
      if (escape_pending_next) begin
        escape_pending_next = 1'b0;
      end else if (c == isc_pkg::CH_BSLASH) begin
        escape_pending_next = 1'b1;
      end else if (c == isc_pkg::CH_QUOTE) begin
        string_open_next = 1'b0;
        last_seen_next   = c;
      end
    end else if (block_open_next) begin
      if (star_seen_next && c == isc_pkg::CH_SLASH) begin
        block_open_next = 1'b0;
        star_seen_next  = 1'b0;
      end else begin
        star_seen_next = (c == isc_pkg::CH_STAR);
      end
    end else if (line_open_next) begin
      if (c == isc_pkg::CH_NL) begin
        line_open_next = 1'b0;
      end
    end else begin
      if (slash_held_next) begin
        slash_held_next = 1'b0;
        if (c == isc_pkg::CH_SLASH) begin
          line_open_next = 1'b1;
          done = 1'b1;
        end else if (c == isc_pkg::CH_STAR) begin
          block_open_next = 1'b1;
          star_seen_next  = 1'b0;
          done = 1'b1;
        end else begin
          // commit the held slash
          if (first_seen_next == isc_pkg::CH_NUL) begin
            first_seen_next = isc_pkg::CH_SLASH;
            first_at_next   = slash_position_next;
          end
          last_seen_next = isc_pkg::CH_SLASH;
        end
      end
      if (!done) begin
        if (c == isc_pkg::CH_SLASH) begin
          slash_held_next     = 1'b1;
          slash_position_next = pos;
        end else if (c == isc_pkg::CH_QUOTE || !isc_pkg::is_space(c)) begin
          if (c == isc_pkg::CH_QUOTE) begin
            string_open_next    = 1'b1;
            escape_pending_next = 1'b0;
          end else if (isc_pkg::is_opener(c)) begin
            if (nest_level_next != DEPTH_MAX) begin
              nest_level_next = nest_level_next + 1'b1;
            end
          end else if (isc_pkg::is_closer(c)) begin
            if (nest_level_next != '0) begin
              nest_level_next = nest_level_next - 1'b1;
            end
          end
          if (first_seen_next == isc_pkg::CH_NUL) begin
            first_seen_next = c;
            first_at_next   = pos;
          end
          last_seen_next = c;
        end
      end
    end

    if (byte_count_next != POS_MAX) begin
      byte_count_next = byte_count_next + 1'b1;
    end

    fc_next = first_seen_next;
    fp_next = first_at_next;
    lc_next = last_seen_next;
    if (slash_held_next) begin
      if (fc_next == isc_pkg::CH_NUL) begin
        fc_next = isc_pkg::CH_SLASH;
        fp_next = slash_position_next;
      end
      lc_next = isc_pkg::CH_SLASH;
    end

    complete_next = !string_open_next && !block_open_next && (nest_level_next == '0) &&
                    (lc_next == isc_pkg::CH_SEMI || lc_next == isc_pkg::CH_RBRACE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      string_open    <= 1'b0;
      escape_pending <= 1'b0;
      block_open     <= 1'b0;
      star_seen      <= 1'b0;
      line_open      <= 1'b0;
      slash_held     <= 1'b0;
      slash_position <= '0;
      nest_level     <= '0;
      first_seen     <= '0;
      first_at       <= '0;
      last_seen      <= '0;
      byte_count     <= '0;
    end else if (advance) begin
      string_open    <= string_open_next;
      escape_pending <= escape_pending_next;
      block_open     <= block_open_next;
      star_seen      <= star_seen_next;
      line_open      <= line_open_next;
      slash_held     <= slash_held_next;
      slash_position <= slash_position_next;
      nest_level     <= nest_level_next;
      first_seen     <= first_seen_next;
      first_at       <= first_at_next;
      last_seen      <= last_seen_next;
      byte_count     <= byte_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      complete   <= complete_next;
      first_char <= fc_next;
      first_pos  <= fp_next;
      last_char  <= lc_next;
      depth      <= nest_level_next;
      in_string  <= string_open_next;
      in_block   <= block_open_next;
    end
  end

  a_string_block_excl: assert property (@(posedge clk) disable iff (rst)
    !(string_open && block_open))
    else $error("string and block comment open together");

  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> string_open)
    else $error("escape pending outside a string");

  a_slash_outside: assert property (@(posedge clk) disable iff (rst)
    slash_held |-> (!string_open && !block_open && !line_open))
    else $error("slash held inside a string or comment");

  a_complete_closed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && complete) |-> (!in_string && !in_block && depth == '0))
    else $error("complete with something still open");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

[bench/tb_item_completeness_scanner_core.sv]
// testbench for item_completeness_scanner_core: directed table, then random text
// checked against a local scanner model, plus a deep nesting phase
// depends on isc_pkg and the core module only
`default_nettype none

module tb_item_completeness_scanner_core;

  localparam int POS_W   = isc_pkg::POS_WIDTH_DEF;
  localparam int DEPTH_W = isc_pkg::DEPTH_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    logic               complete;
    logic [7:0]         first_char;
    logic [POS_W-1:0]   first_pos;
    logic [7:0]         last_char;
    logic [DEPTH_W-1:0] depth;
    logic               in_string;
    logic               in_block;
  } scan_result_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         fresh;
    logic         typed;
    scan_result_t want;
  } stim_row_t;

  localparam scan_result_t NONE = '0;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] char_code;
  logic new_item;
  logic out_valid;
  logic out_stall;
  logic complete;
  logic [7:0] first_char;
  logic [POS_W-1:0] first_pos;
  logic [7:0] last_char;
  logic [DEPTH_W-1:0] depth;
  logic in_string;
  logic in_block;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_completeness_scanner_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .new_item   (new_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .complete   (complete),
    .first_char (first_char),
    .first_pos  (first_pos),
    .last_char  (last_char),
    .depth      (depth),
    .in_string  (in_string),
    .in_block   (in_block)
  );

  // scanner model state
  logic               s_str, s_esc, s_blk, s_star, s_line, s_slash;
  logic [POS_W-1:0]   s_slash_pos, s_count, s_first_at;
  logic [DEPTH_W-1:0] s_depth;
  logic [7:0]         s_first, s_last;

  scan_result_t pending_scans [$];
  scan_result_t predicted, due;
  logic         cur_typed;
  scan_result_t cur_want;
  int           inputs_taken = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int unsigned  cycles = 0;
  logic         pressure_done = 1'b0;
  int           calm_left = 0;
  logic [7:0]   text_bytes [$];

  stim_row_t stim_tab [27] = '{
    '{isc_pkg::CH_LBRACE, 1'b1, 1'b0, NONE},
    '{isc_pkg::CH_LPAREN, 1'b0, 1'b0, NONE},
    '{isc_pkg::CH_LBRACK, 1'b0, 1'b0, NONE},
    '{isc_pkg::CH_RBRACK, 1'b0, 1'b0, NONE},
    '{isc_pkg::CH_RPAREN, 1'b0, 1'b0, NONE},
    '{isc_pkg::CH_RBRACE, 1'b0, 1'b1,
      '{1'b1, isc_pkg::CH_LBRACE, 16'd0, isc_pkg::CH_RBRACE, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SPACE,  1'b1, 1'b1, NONE},
    '{isc_pkg::CH_SEMI,   1'b1, 1'b1,
      '{1'b1, isc_pkg::CH_SEMI, 16'd0, isc_pkg::CH_SEMI, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SLASH,  1'b1, 1'b1,
      '{1'b0, isc_pkg::CH_SLASH, 16'd0, isc_pkg::CH_SLASH, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SLASH,  1'b0, 1'b1, NONE},
    '{"q",                1'b0, 1'b0, NONE},
    '{isc_pkg::CH_NL,     1'b0, 1'b0, NONE},
    '{isc_pkg::CH_RPAREN, 1'b0, 1'b1,
      '{1'b0, isc_pkg::CH_RPAREN, 16'd4, isc_pkg::CH_RPAREN, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SLASH,  1'b1, 1'b0, NONE},
    '{isc_pkg::CH_STAR,   1'b0, 1'b1,
      '{1'b0, isc_pkg::CH_NUL, 16'd0, isc_pkg::CH_NUL, 8'd0, 1'b0, 1'b1}},
    '{isc_pkg::CH_STAR,   1'b0, 1'b0, NONE},
    '{isc_pkg::CH_SLASH,  1'b0, 1'b1, NONE},
    '{isc_pkg::CH_QUOTE,  1'b1, 1'b1,
      '{1'b0, isc_pkg::CH_QUOTE, 16'd0, isc_pkg::CH_QUOTE, 8'd0, 1'b1, 1'b0}},
    '{isc_pkg::CH_BSLASH, 1'b0, 1'b0, NONE},
    '{isc_pkg::CH_QUOTE,  1'b0, 1'b0, NONE},
    '{isc_pkg::CH_QUOTE,  1'b0, 1'b1,
      '{1'b0, isc_pkg::CH_QUOTE, 16'd0, isc_pkg::CH_QUOTE, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SEMI,   1'b0, 1'b0, NONE},
    '{isc_pkg::CH_SPACE,  1'b1, 1'b0, NONE},
    '{isc_pkg::CH_NUL,    1'b0, 1'b1,
      '{1'b0, isc_pkg::CH_NUL, 16'd1, isc_pkg::CH_NUL, 8'd0, 1'b0, 1'b0}},
    '{8'hff,              1'b0, 1'b1, '{1'b0, 8'hff, 16'd2, 8'hff, 8'd0, 1'b0, 1'b0}},
    '{isc_pkg::CH_SLASH,  1'b0, 1'b0, NONE},
    '{"a",                1'b0, 1'b0, NONE}
  };

  task clear_scan();
    s_str = 1'b0;
    s_esc = 1'b0;
    s_blk = 1'b0;
    s_star = 1'b0;
    s_line = 1'b0;
    s_slash = 1'b0;
    s_slash_pos = '0;
    s_count = '0;
    s_first_at = '0;
    s_depth = '0;
    s_first = '0;
    s_last = '0;
  endtask

  task mark_significant(input logic [7:0] c, input logic [POS_W-1:0] pos);
    if (s_first == 8'd0) begin
      s_first = c;
      s_first_at = pos;
    end
    s_last = c;
  endtask

  task scan_byte(input logic [7:0] c, input logic fresh, output scan_result_t r);
    logic [POS_W-1:0] pos;
    logic taken;
    if (fresh) clear_scan();
    pos = s_count;
    taken = 1'b0;
    if (s_str) begin
      if (s_esc) begin
        s_esc = 1'b0;
      end else if (c == isc_pkg::CH_BSLASH) begin
        s_esc = 1'b1;
      end else if (c == isc_pkg::CH_QUOTE) begin
        s_str = 1'b0;
        s_last = c;
      end
    end else if (s_blk) begin
      if (s_star && c == isc_pkg::CH_SLASH) begin
        s_blk = 1'b0;
        s_star = 1'b0;
      end else begin
        s_star = (c == isc_pkg::CH_STAR);
      end
    end else if (s_line) begin
      if (c == isc_pkg::CH_NL) s_line = 1'b0;
    end else begin
      if (s_slash) begin
        s_slash = 1'b0;
        if (c == isc_pkg::CH_SLASH) begin
          s_line = 1'b1;
          taken = 1'b1;
        end else if (c == isc_pkg::CH_STAR) begin
          s_blk = 1'b1;
          s_star = 1'b0;
          taken = 1'b1;
        end else begin
          mark_significant(isc_pkg::CH_SLASH, s_slash_pos);
        end
      end
      if (!taken) begin
        if (c == isc_pkg::CH_SLASH) begin
          s_slash = 1'b1;
          s_slash_pos = pos;
        end else if (c == isc_pkg::CH_QUOTE) begin
          s_str = 1'b1;
          s_esc = 1'b0;
          mark_significant(c, pos);
        end else if (!(c == isc_pkg::CH_SPACE || c == isc_pkg::CH_TAB ||
                       c == isc_pkg::CH_NL || c == isc_pkg::CH_VT ||
                       c == isc_pkg::CH_FF || c == isc_pkg::CH_CR)) begin
          if (c == isc_pkg::CH_LPAREN || c == isc_pkg::CH_LBRACK ||
              c == isc_pkg::CH_LBRACE) begin
            if (s_depth != '1) s_depth = s_depth + 1'b1;
          end else if (c == isc_pkg::CH_RPAREN || c == isc_pkg::CH_RBRACK ||
                       c == isc_pkg::CH_RBRACE) begin
            if (s_depth != '0) s_depth = s_depth - 1'b1;
          end
          mark_significant(c, pos);
        end
      end
    end
    if (s_count != '1) s_count = s_count + 1'b1;

    r.first_char = s_first;
    r.first_pos = s_first_at;
    r.last_char = s_last;
    // an undecided slash still shows as significant
    if (s_slash) begin
      if (r.first_char == 8'd0) begin
        r.first_char = isc_pkg::CH_SLASH;
        r.first_pos = s_slash_pos;
      end
      r.last_char = isc_pkg::CH_SLASH;
    end
    r.depth = s_depth;
    r.in_string = s_str;
    r.in_block = s_blk;
    r.complete = !s_str && !s_blk && s_depth == '0 &&
                 (r.last_char == isc_pkg::CH_SEMI || r.last_char == isc_pkg::CH_RBRACE);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] blank();
    case ($urandom_range(0, 7))
      0: return isc_pkg::CH_TAB;
      1: return isc_pkg::CH_NL;
      2: return isc_pkg::CH_VT;
      3: return isc_pkg::CH_FF;
      4: return isc_pkg::CH_CR;
      default: return isc_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] bracket(input logic closing);
    case ($urandom_range(0, 2))
      0: return closing ? isc_pkg::CH_RPAREN : isc_pkg::CH_LPAREN;
      1: return closing ? isc_pkg::CH_RBRACK : isc_pkg::CH_LBRACK;
      default: return closing ? isc_pkg::CH_RBRACE : isc_pkg::CH_LBRACE;
    endcase
  endfunction

  // one random statement: words, strings, comments, brackets, then a terminator
  task build_text();
    int open;
    logic [7:0] b;
    text_bytes.delete();
    open = 0;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(8'h61, 8'h7a));
          text_bytes.push_back(b);
        end
        1: text_bytes.push_back(blank());
        2: begin
          text_bytes.push_back(isc_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) text_bytes.push_back(isc_pkg::CH_BSLASH);
            b = 8'($urandom_range(0, 255));
            if (b == isc_pkg::CH_QUOTE && $urandom_range(0, 1) == 0) b = isc_pkg::CH_SPACE;
            text_bytes.push_back(b);
          end
          if ($urandom_range(0, 9) != 0) text_bytes.push_back(isc_pkg::CH_QUOTE);
        end
        3: begin
          text_bytes.push_back(isc_pkg::CH_SLASH);
          text_bytes.push_back(isc_pkg::CH_SLASH);
          repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == isc_pkg::CH_NL) b = isc_pkg::CH_SEMI;
            text_bytes.push_back(b);
          end
          text_bytes.push_back(isc_pkg::CH_NL);
        end
        4: begin
          text_bytes.push_back(isc_pkg::CH_SLASH);
          text_bytes.push_back(isc_pkg::CH_STAR);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
              0: b = isc_pkg::CH_STAR;
              1: b = isc_pkg::CH_SLASH;
              default: b = 8'($urandom_range(0, 255));
            endcase
            text_bytes.push_back(b);
          end
          text_bytes.push_back(isc_pkg::CH_STAR);
          text_bytes.push_back(isc_pkg::CH_SLASH);
        end
        5, 6: begin
          text_bytes.push_back(bracket(1'b0));
          open++;
        end
        7: begin
          text_bytes.push_back(bracket(1'b1));
          if (open > 0) open--;
        end
        8: begin
          text_bytes.push_back(isc_pkg::CH_SLASH);
          b = 8'($urandom_range(8'h61, 8'h7a));
          text_bytes.push_back(b);
        end
        9: text_bytes.push_back(isc_pkg::CH_SEMI);
        10: begin
          b = 8'($urandom_range(0, 255));
          text_bytes.push_back(b);
        end
        default: text_bytes.push_back($urandom_range(0, 1) ? isc_pkg::CH_NUL : 8'hff);
      endcase
    end
    repeat (open) text_bytes.push_back(bracket(1'b1));
    text_bytes.push_back($urandom_range(0, 1) ? isc_pkg::CH_SEMI : isc_pkg::CH_RBRACE);
    // broken statement now and then
    if ($urandom_range(0, 7) == 0 && text_bytes.size() > 1)
      text_bytes.delete(text_bytes.size() - 1);
  endtask

  task send_byte(input logic [7:0] c, input logic fresh, input logic typed,
                 input scan_result_t want);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(15, 40);
    end
    gap = (calm_left > 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    char_code = c;
    new_item = fresh;
    cur_typed = typed;
    cur_want = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        scan_byte(char_code, new_item, predicted);
        pending_scans.push_back(cur_typed ? cur_want : predicted);
        inputs_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_scans.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          due = pending_scans.pop_front();
          if (complete !== due.complete)
            report_mismatch("complete", 32'(complete), 32'(due.complete));
          if (first_char !== due.first_char)
            report_mismatch("first_char", 32'(first_char), 32'(due.first_char));
          if (first_pos !== due.first_pos)
            report_mismatch("first_pos", 32'(first_pos), 32'(due.first_pos));
          if (last_char !== due.last_char)
            report_mismatch("last_char", 32'(last_char), 32'(due.last_char));
          if (depth !== due.depth)
            report_mismatch("depth", 32'(depth), 32'(due.depth));
          if (in_string !== due.in_string)
            report_mismatch("in_string", 32'(in_string), 32'(due.in_string));
          if (in_block !== due.in_block)
            report_mismatch("in_block", 32'(in_block), 32'(due.in_block));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("item_completeness_scanner_core test failed");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int hold_left;
    int run_left;
    hold_left = 0;
    run_left = 0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (!pressure_done && inputs_taken >= 120) begin
        pressure_done = 1'b1;
        out_stall = 1'b1;
        hold_left = 90;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 9) < 6) begin
        out_stall = 1'b0;
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      end else begin
        out_stall = 1'b1;
        run_left = idle_len();
      end
      @(negedge clk);
    end
  end

  initial begin
    int rand_sent;
    logic fresh;
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    new_item = 1'b0;
    cur_typed = 1'b0;
    cur_want = NONE;
    clear_scan();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (stim_tab[i])
      send_byte(stim_tab[i].ch, stim_tab[i].fresh, stim_tab[i].typed, stim_tab[i].want);

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      build_text();
      fresh = ($urandom_range(0, 4) != 0);
      foreach (text_bytes[i]) begin
        send_byte(text_bytes[i], (i == 0) ? fresh : ($urandom_range(0, 80) == 0),
                  1'b0, NONE);
        rand_sent++;
      end
    end

    // depth saturation, then closers counting down from the top
    send_byte(isc_pkg::CH_LPAREN, 1'b1, 1'b0, NONE);
    repeat (259) send_byte(bracket(1'b0), 1'b0, 1'b0, NONE);
    repeat (3) send_byte(bracket(1'b1), 1'b0, 1'b0, NONE);
    send_byte(isc_pkg::CH_SEMI, 1'b0, 1'b0, NONE);

    in_valid = 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("item_completeness_scanner_core test passed");
    end else begin
      $display("item_completeness_scanner_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
